@@ src/audio_ring_dma_with_half_full_irq_defines.svh @@
// ----------------------------------------------------------------------------
// Audio ring DMA assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RING_DMA_WITH_HALF_FULL_IRQ_DEFINES_SVH
`define AUDIO_RING_DMA_WITH_HALF_FULL_IRQ_DEFINES_SVH

// same-cycle implication
`define ARDMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARDMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ardma_pkg.sv @@
// ----------------------------------------------------------------------------
// Audio ring DMA package
// Operation and register codes and fixed register values.
// ----------------------------------------------------------------------------
package ardma_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  localparam logic [1:0] REG_CONFIG = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  // stereo flag in bit 31, sample rate 44100 Hz below
  localparam logic [31:0] FORMAT_WORD   = 32'h8000_0000 | 32'd44100;
  localparam logic [31:0] LOW_BITS_MASK = 32'h0000_0007;

  localparam int CLEAR_HALF_BIT = 0;
  localparam int CLEAR_FULL_BIT = 1;

endpackage

@@ src/audio_ring_dma_with_half_full_irq.sv @@
// ----------------------------------------------------------------------------
// Audio ring DMA with half/full interrupts
// Register access and sample address generation for a ring playback buffer.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | op, reg_index, write_data
//  out     | out_valid / out_ready| read_data, bus_error, fetch_enable,
//          |                      | fetch_address, irq_half, irq_full
//
//  One transfer per cycle while in_ready is high; its result is presented the cycle after the transfer.
//  Position update is a single increment and two compares ahead of the result register.
//  in_ready drops only while a result is held and out_ready is low.
//  Synchronous reset clears out_valid and the control state, not the result register; no output is valid after reset.
// ----------------------------------------------------------------------------
module audio_ring_dma_with_half_full_irq
  import ardma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [1:0]  reg_index,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        bus_error,
  output logic        fetch_enable,
  output logic [31:0] fetch_address,
  output logic        irq_half,
  output logic        irq_full
);

  logic        playing;
  logic [31:0] base_address;
  logic [31:0] length_bytes;
  logic [29:0] position;
  logic        half_pending;
  logic        full_pending;

  logic        playing_next;
  logic [31:0] base_address_next;
  logic [31:0] length_bytes_next;
  logic [29:0] position_next;
  logic        half_pending_next;
  logic        full_pending_next;

  logic [31:0] read_data_next;
  logic        bus_error_next;
  logic        fetch_enable_next;
  logic [31:0] fetch_address_next;

  logic [29:0] total;
  logic [29:0] half;
  logic [29:0] pos_inc;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign total   = length_bytes[31:2];
  assign half    = {1'b0, total[29:1]};
  assign pos_inc = position + 30'd1;

  always_comb begin
    playing_next       = playing;
    base_address_next  = base_address;
    length_bytes_next  = length_bytes;
    position_next      = position;
    half_pending_next  = half_pending;
    full_pending_next  = full_pending;
    read_data_next     = '0;
    bus_error_next     = 1'b0;
    fetch_enable_next  = 1'b0;
    fetch_address_next = '0;

    case (op)
      OP_READ: begin
        case (reg_index)
          REG_CONFIG: read_data_next = FORMAT_WORD;
          REG_LENGTH: read_data_next = length_bytes;
          default:    bus_error_next = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (reg_index)
          REG_CONFIG: begin
            if (write_data[CLEAR_HALF_BIT]) begin
              half_pending_next = 1'b0;
            end
            if (write_data[CLEAR_FULL_BIT]) begin
              full_pending_next = 1'b0;
            end
          end
          REG_LENGTH: begin
            length_bytes_next = write_data & ~LOW_BITS_MASK;
            playing_next      = |(write_data & ~LOW_BITS_MASK);
            position_next     = '0;
          end
          REG_BASE: begin
            base_address_next = write_data & ~LOW_BITS_MASK;
            position_next     = '0;
          end
          default: bus_error_next = 1'b1;
        endcase
      end
      OP_PULL: begin
        if (playing) begin
          fetch_enable_next  = 1'b1;
          fetch_address_next = base_address + {position, 2'b00};
          position_next      = pos_inc;
          if (pos_inc == half) begin
            half_pending_next = 1'b1;
          end
          if (pos_inc == total) begin
            full_pending_next = 1'b1;
            position_next     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      playing      <= 1'b0;
      base_address <= '0;
      length_bytes <= '0;
      position     <= '0;
      half_pending <= 1'b0;
      full_pending <= 1'b0;
    end else begin
      if (accept) begin
        out_valid    <= 1'b1;
        playing      <= playing_next;
        base_address <= base_address_next;
        length_bytes <= length_bytes_next;
        position     <= position_next;
        half_pending <= half_pending_next;
        full_pending <= full_pending_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data     <= read_data_next;
      bus_error     <= bus_error_next;
      fetch_enable  <= fetch_enable_next;
      fetch_address <= fetch_address_next;
      irq_half      <= half_pending_next;
      irq_full      <= full_pending_next;
    end
  end

endmodule

@@ src/ardma_checker.sv @@
// ----------------------------------------------------------------------------
// Audio ring DMA port checker
// Port-level properties of the ring DMA, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_ring_dma_with_half_full_irq_defines.svh"

module ardma_checker
  import ardma_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  op,
  input logic [1:0]  reg_index,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        bus_error,
  input logic        fetch_enable,
  input logic [31:0] fetch_address,
  input logic        irq_half,
  input logic        irq_full
);

  logic        in_xfer;
  logic        bus_op;
  logic        out_stall;
  logic [67:0] res_word;
  logic        cfg_read;
  logic        format_ok;
  logic        err_access;
  logic        out_err;
  logic        out_silent;

  assign in_xfer    = in_valid && in_ready;
  assign bus_op     = (op == OP_READ) || (op == OP_WRITE);
  assign out_stall  = out_valid && !out_ready;
  assign res_word   = {read_data, bus_error, fetch_enable, fetch_address, irq_half, irq_full};
  assign cfg_read   = in_xfer && op == OP_READ && reg_index == REG_CONFIG;
  assign format_ok  = out_valid && read_data == FORMAT_WORD && !bus_error;
  assign err_access = in_xfer && bus_op && reg_index != REG_CONFIG && reg_index != REG_LENGTH
                      && !(op == OP_WRITE && reg_index == REG_BASE);
  assign out_err    = out_valid && bus_error;
  assign out_silent = out_valid && !fetch_enable;

  `ARDMA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_word), "held result changed")

  `ARDMA_ASSERT_NEXT(a_format_read, cfg_read, format_ok, "config read returned wrong word")

  `ARDMA_ASSERT_NEXT(a_unmapped_err, err_access, out_valid && bus_error, "missing bus error")

  `ARDMA_ASSERT_NOW(a_err_clean, out_err, read_data == '0 && !fetch_enable, "dirty bus error")

  `ARDMA_ASSERT_NOW(a_silent_addr, out_silent, fetch_address == '0, "address without fetch")

endmodule

bind audio_ring_dma_with_half_full_irq ardma_checker u_ardma_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .op            (op),
  .reg_index     (reg_index),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .read_data     (read_data),
  .bus_error     (bus_error),
  .fetch_enable  (fetch_enable),
  .fetch_address (fetch_address),
  .irq_half      (irq_half),
  .irq_full      (irq_full)
);

@@ dv/tb_audio_ring_dma_with_half_full_irq.sv @@
// ----------------------------------------------------------------------------
// Audio ring DMA testbench
// Drives register accesses and sample pulls through the valid/ready channels.
// A scoreboard predicts every result from its own model of the ring position,
// the interrupt flags and the registers, and checks each returned transfer
// field by field. Random bursts and gaps on the input side and a varying stall
// pattern on the output side, with one long output hold-off that backs up the
// input.
// ----------------------------------------------------------------------------
module tb_audio_ring_dma_with_half_full_irq;
  import ardma_pkg::*;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int RANDOM_ITEMS    = 1250;
  localparam int LONG_HOLD_START = 600;
  localparam int LONG_HOLD_LEN   = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_error;
    logic        fetch_enable;
    logic [31:0] fetch_address;
    logic        irq_half;
    logic        irq_full;
  } dma_result_t;

  class dma_scoreboard;
    dma_result_t expected_results[$];
    int          error_count;
    int          fetches;
    int          silent_pulls;
    int          bus_errors;
    int          wraps;
    int          checked;
    bit          playing;
    logic [31:0] buf_base;
    logic [31:0] buf_length;
    logic [29:0] ring_pos;
    bit          half_flag;
    bit          full_flag;

    function dma_result_t predict_outcome(logic [1:0] op_i, logic [1:0] ri,
                                          logic [31:0] wd);
      dma_result_t r;
      logic [29:0] total;
      logic [29:0] half_mark;
      r = '0;
      case (op_i)
        OP_READ: begin
          case (ri)
            REG_CONFIG: r.read_data = FORMAT_WORD;
            REG_LENGTH: r.read_data = buf_length;
            default:    r.bus_error = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (ri)
            REG_CONFIG: begin
              if (wd[CLEAR_HALF_BIT]) half_flag = 1'b0;
              if (wd[CLEAR_FULL_BIT]) full_flag = 1'b0;
            end
            REG_LENGTH: begin
              buf_length = wd & ~LOW_BITS_MASK;
              playing    = (buf_length != 32'd0);
              ring_pos   = '0;
            end
            REG_BASE: begin
              buf_base = wd & ~LOW_BITS_MASK;
              ring_pos = '0;
            end
            default: r.bus_error = 1'b1;
          endcase
        end
        OP_PULL: begin
          if (playing) begin
            total          = buf_length[31:2];
            half_mark      = total >> 1;
            r.fetch_enable  = 1'b1;
            r.fetch_address = buf_base + {ring_pos, 2'b00};
            ring_pos       = ring_pos + 30'd1;
            if (ring_pos == half_mark) half_flag = 1'b1;
            if (ring_pos == total) begin
              full_flag = 1'b1;
              ring_pos  = '0;
              wraps++;
            end
            fetches++;
          end else begin
            silent_pulls++;
          end
        end
        default: ;
      endcase
      if (r.bus_error) bus_errors++;
      r.irq_half = half_flag;
      r.irq_full = full_flag;
      return r;
    endfunction

    function void note_transfer(logic [1:0] op_i, logic [1:0] ri, logic [31:0] wd);
      expected_results.push_back(predict_outcome(op_i, ri, wd));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        error_count++;
      end
    endfunction

    function void check_result(dma_result_t act);
      dma_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        error_count++;
        return;
      end
      exp_r = expected_results.pop_front();
      checked++;
      compare_field("read_data",     exp_r.read_data,     act.read_data);
      compare_field("bus_error",     exp_r.bus_error,     act.bus_error);
      compare_field("fetch_enable",  exp_r.fetch_enable,  act.fetch_enable);
      compare_field("fetch_address", exp_r.fetch_address, act.fetch_address);
      compare_field("irq_half",      exp_r.irq_half,      act.irq_half);
      compare_field("irq_full",      exp_r.irq_full,      act.irq_full);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [1:0]  reg_index;
  logic [31:0] write_data;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] read_data;
  logic        bus_error;
  logic        fetch_enable;
  logic [31:0] fetch_address;
  logic        irq_half;
  logic        irq_full;

  dma_scoreboard sb;
  int            transfers_in;
  int            idle_cycles;
  bit            long_hold_done;

  audio_ring_dma_with_half_full_irq i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .bus_error    (bus_error),
    .fetch_enable (fetch_enable),
    .fetch_address(fetch_address),
    .irq_half     (irq_half),
    .irq_full     (irq_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // output checked before the same-edge input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result('{read_data, bus_error, fetch_enable, fetch_address,
                          irq_half, irq_full});
      if (in_valid && in_ready) begin
        sb.note_transfer(op, reg_index, write_data);
        transfers_in++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no transfer for %0d cycles", $time,
                 WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: stall pattern changes per segment, plus one long hold-off
  initial begin
    int rx_mode;
    int rx_left;
    int rx_phase;
    rx_mode   = 0;
    rx_left   = 0;
    rx_phase  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && transfers_in >= LONG_HOLD_START) begin
        long_hold_done = 1'b1;
        out_ready      = 1'b0;
        repeat (LONG_HOLD_LEN) @(negedge clk);
      end
      if (rx_left == 0) begin
        rx_mode  = $urandom_range(0, 3);
        rx_left  = $urandom_range(8, 60);
        rx_phase = 0;
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_ready = 1'b1;
        1:       out_ready = $urandom_range(0, 1);
        2:       out_ready = (rx_phase % 3) != 0;
        default: out_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_item(input logic [1:0] op_i, input logic [1:0] ri,
                           input logic [31:0] wd);
    @(negedge clk);
    in_valid   = 1'b1;
    op         = op_i;
    reg_index  = ri;
    write_data = wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid   = 1'b0;
      op         = 2'($urandom);
      reg_index  = 2'($urandom);
      write_data = $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_length();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 32'($urandom_range(0, 7));
    if (k == 1) return $urandom;
    return 32'($urandom_range(8, 200));
  endfunction

  task automatic send_random_item();
    int          sel;
    logic [31:0] wd;
    sel = $urandom_range(0, 99);
    wd  = $urandom;
    if (sel < 60)      send_item(OP_PULL, 2'($urandom), wd);
    else if (sel < 66) send_item(OP_WRITE, REG_LENGTH, pick_length());
    else if (sel < 71) send_item(OP_WRITE, REG_BASE, wd);
    else if (sel < 79) send_item(OP_WRITE, REG_CONFIG, wd);
    else if (sel < 89) send_item(OP_READ, 2'($urandom_range(0, 3)), wd);
    else if (sel < 92) send_item(OP_WRITE, REG_UNMAPPED, wd);
    else if (sel < 95) send_item(OP_UNDEFINED, 2'($urandom), wd);
    else               send_item(OP_READ, REG_CONFIG, 32'd0);
  endtask

  initial begin
    int sent;
    int burst;
    sb             = new();
    transfers_in   = 0;
    idle_cycles    = 0;
    long_hold_done = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_READ;
    reg_index      = REG_CONFIG;
    write_data     = 32'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: register map, silence, tiny ring at the top of memory, clears
    send_item(OP_READ,      REG_CONFIG,   32'd0);
    send_item(OP_READ,      REG_LENGTH,   32'd0);
    send_item(OP_READ,      REG_BASE,     32'd0);
    send_item(OP_READ,      REG_UNMAPPED, 32'd0);
    send_item(OP_WRITE,     REG_UNMAPPED, 32'hFFFF_FFFF);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_UNDEFINED, REG_UNMAPPED, 32'hFFFF_FFFF);
    send_item(OP_WRITE,     REG_BASE,     32'hFFFF_FFFF);
    send_item(OP_WRITE,     REG_LENGTH,   32'h0000_000F);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_WRITE,     REG_CONFIG,   32'd0);
    send_item(OP_WRITE,     REG_CONFIG,   32'd1 << CLEAR_HALF_BIT);
    send_item(OP_WRITE,     REG_CONFIG,   32'd1 << CLEAR_FULL_BIT);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_WRITE,     REG_BASE,     32'd0);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_WRITE,     REG_LENGTH,   32'hFFFF_FFFF);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_READ,      REG_LENGTH,   32'd0);
    send_item(OP_WRITE,     REG_LENGTH,   32'd0);
    send_item(OP_PULL,      REG_CONFIG,   32'd0);
    send_item(OP_WRITE,     REG_CONFIG,   32'hFFFF_FFFF);
    send_item(OP_WRITE,     REG_LENGTH,   32'd24);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_item();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers in, %0d results checked, %0d mismatches.",
             transfers_in, sb.checked, sb.error_count);
    $display("Sample fetches %0d, silent pulls %0d, bus errors %0d, ring wraps %0d.",
             sb.fetches, sb.silent_pulls, sb.bus_errors, sb.wraps);
    if (sb.error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
